>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, all clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every clock edge outside reset.
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 package
// Types, constants and command structure shared by the SHA-1 modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned RND_W        = 7;
  localparam int unsigned OIDX_W       = 3;

  localparam logic [POS_W-1:0]  POS_LEN_HI = 4'd14;
  localparam logic [POS_W-1:0]  POS_LAST   = 4'd15;
  localparam logic [RND_W-1:0]  RND_LAST   = 7'd79;
  localparam logic [RND_W-1:0]  RND_STG1   = 7'd20;
  localparam logic [RND_W-1:0]  RND_STG2   = 7'd40;
  localparam logic [RND_W-1:0]  RND_STG3   = 7'd60;
  localparam logic [OIDX_W-1:0] OIDX_LAST  = 3'd4;
  localparam logic [2:0]        FULL_BYTES = 3'd4;

  localparam logic [31:0] MARK_WORD = 32'h8000_0000;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [31:0] IV [DIGEST_WORDS] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha1_state_t;

  // Source of the word pushed into the block buffer.
  typedef enum logic [2:0] {
    SRC_DATA,
    SRC_LAST,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } sha1_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept;
    logic              push;
    sha1_src_t         src;
    logic              load_work;
    logic              round_en;
    logic [RND_W-1:0]  rnd;
    logic              add_en;
    logic              clear;
    logic [OIDX_W-1:0] out_idx;
  } sha1_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Streams big-endian message words, pads the final block and returns the
// five 32-bit digest words.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  in_       input      in_valid/in_stall   data_word, valid_bytes, last_word
//  out_      output     out_valid/out_stall digest_word, digest_last
//
//  A word that does not fill the block and is not the last word leaves the
//  engine ready for the next word. The sixteenth word of a block starts the
//  compression: 80 rounds at one round a cycle, then the chaining add; no input
//  is taken until it has finished. The last word is followed by the padding
//  words, one or two compressions and five output transfers. Reset is
//  synchronous and restores the initial values. out_stall holds the current
//  digest word; no input is taken until the fifth word has been transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sha1_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic             out_digest_last
);

  sha1_pkg::sha1_cmd_t cmd;

  // Sequencer for intake, padding, rounds and output.
  sha1_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_word    (in_last_word),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_last (out_digest_last),
    .cmd             (cmd)
  );

  // Buffer, schedule, round logic and chaining values.
  sha1_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .digest_word    (out_digest_word)
  );

  // No input transfer while the digest is being delivered.
  `SHA_ASSERT_IMP(a_no_in_during_out, out_valid, in_stall, "input taken during digest output")

  // A buffer push never overlaps a compression round.
  `SHA_ASSERT_IMP(a_push_not_round, cmd.push, !cmd.round_en, "push during round")

  // Working variables load only on the push that completes a block.
  `SHA_ASSERT_IMP(a_load_on_push, cmd.load_work, cmd.push, "load without push")

  // The final digest transfer ends the output phase.
  `SHA_ASSERT_NEXT(a_out_ends, out_valid && !out_stall && out_digest_last, !out_valid,
                   "output continues after last digest word")

endmodule

`default_nettype wire

>>> rtl/core/sha1_datapath.sv
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer and message schedule window, round logic, chaining values and
// the message bit-length counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sha1_pkg::sha1_cmd_t cmd,
  input  wire logic [31:0]        in_data_word,
  input  wire logic [2:0]         in_valid_bytes,
  input  wire logic               in_last_word,
  output logic [31:0]             digest_word
);

  logic [31:0] win_r [sha1_pkg::BLOCK_WORDS];
  logic [31:0] win_nxt [sha1_pkg::BLOCK_WORDS];
  logic [31:0] cv_r [sha1_pkg::DIGEST_WORDS];
  logic [31:0] cv_nxt [sha1_pkg::DIGEST_WORDS];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  vb_sat;
  logic [31:0] last_word_pad;
  logic [31:0] push_word;
  logic [31:0] sched_word;
  logic [31:0] sched_mix;
  logic [31:0] f_val, k_val, t_val;

  // Byte count of the final word, saturated to a full word.
  assign vb_sat = (in_valid_bytes > sha1_pkg::FULL_BYTES) ? sha1_pkg::FULL_BYTES
                                                          : in_valid_bytes;

  // Final partial word: keep the valid bytes and place the marker byte after them.
  always_comb begin
    unique case (vb_sat)
      3'd0:    last_word_pad = sha1_pkg::MARK_WORD;
      3'd1:    last_word_pad = {in_data_word[31:24], 24'h80_0000};
      3'd2:    last_word_pad = {in_data_word[31:16], 16'h8000};
      3'd3:    last_word_pad = {in_data_word[31:8], 8'h80};
      default: last_word_pad = in_data_word;
    endcase
  end

  // Word pushed into the block buffer.
  always_comb begin
    unique case (cmd.src)
      sha1_pkg::SRC_DATA:   push_word = in_data_word;
      sha1_pkg::SRC_LAST:   push_word = last_word_pad;
      sha1_pkg::SRC_MARK:   push_word = sha1_pkg::MARK_WORD;
      sha1_pkg::SRC_LEN_HI: push_word = len_r[63:32];
      sha1_pkg::SRC_LEN_LO: push_word = len_r[31:0];
      default:              push_word = '0;
    endcase
  end

  // Message schedule: the window holds w[r..r+15], so the next word is formed
  // from fixed taps and shifted in at the top.
  assign sched_mix  = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign sched_word = {sched_mix[30:0], sched_mix[31]};

  always_comb begin
    for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++) begin
      win_nxt[i] = (cmd.push || cmd.round_en) ? win_r[i+1] : win_r[i];
    end
    if (cmd.push) begin
      win_nxt[sha1_pkg::BLOCK_WORDS-1] = push_word;
    end else if (cmd.round_en) begin
      win_nxt[sha1_pkg::BLOCK_WORDS-1] = sched_word;
    end else begin
      win_nxt[sha1_pkg::BLOCK_WORDS-1] = win_r[sha1_pkg::BLOCK_WORDS-1];
    end
  end

  // Round function and constant for the current group of twenty rounds.
  always_comb begin
    priority if (cmd.rnd < sha1_pkg::RND_STG1) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = sha1_pkg::K0;
    end else if (cmd.rnd < sha1_pkg::RND_STG2) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1_pkg::K1;
    end else if (cmd.rnd < sha1_pkg::RND_STG3) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = sha1_pkg::K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1_pkg::K3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + k_val + win_r[0] + e_r;

  // Working variables: loaded from the chaining values, then one round a cycle.
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (cmd.load_work) begin
      a_nxt = cv_r[0];
      b_nxt = cv_r[1];
      c_nxt = cv_r[2];
      d_nxt = cv_r[3];
      e_nxt = cv_r[4];
    end else if (cmd.round_en) begin
      a_nxt = t_val;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
  end

  // Chaining values: add the block result, or return to the initial values.
  always_comb begin
    for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
      cv_nxt[i] = cv_r[i];
    end
    if (cmd.clear) begin
      for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
        cv_nxt[i] = sha1_pkg::IV[i];
      end
    end else if (cmd.add_en) begin
      cv_nxt[0] = cv_r[0] + a_r;
      cv_nxt[1] = cv_r[1] + b_r;
      cv_nxt[2] = cv_r[2] + c_r;
      cv_nxt[3] = cv_r[3] + d_r;
      cv_nxt[4] = cv_r[4] + e_r;
    end
  end

  // Message bit length, counted on every accepted word.
  always_comb begin
    len_nxt = len_r;
    if (cmd.clear) begin
      len_nxt = '0;
    end else if (cmd.accept) begin
      if (in_last_word) begin
        len_nxt = len_r + {58'd0, vb_sat, 3'b000};
      end else begin
        len_nxt = len_r + 64'd32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
        cv_r[i] <= sha1_pkg::IV[i];
      end
      len_r <= '0;
    end else begin
      cv_r  <= cv_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

  // Digest word selected by the controller's output index.
  always_comb begin
    unique case (cmd.out_idx)
      3'd0:    digest_word = cv_r[0];
      3'd1:    digest_word = cv_r[1];
      3'd2:    digest_word = cv_r[2];
      3'd3:    digest_word = cv_r[3];
      default: digest_word = cv_r[4];
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences word intake, padding, the 80 compression rounds and digest output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_valid_bytes,
  input  wire logic       in_last_word,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_digest_last,
  output sha1_pkg::sha1_cmd_t cmd
);

  sha1_pkg::sha1_state_t state_r, state_nxt;
  logic [sha1_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [sha1_pkg::RND_W-1:0]  rnd_r, rnd_nxt;
  logic [sha1_pkg::OIDX_W-1:0] oidx_r, oidx_nxt;
  logic pad_r, pad_nxt;
  logic mark_r, mark_nxt;
  logic hi_r, hi_nxt;
  logic accept;
  logic push;
  logic wrap;
  logic out_xfer;
  logic out_done;

  assign accept   = (state_r == sha1_pkg::ST_IDLE) && in_valid;
  assign push     = accept || (state_r == sha1_pkg::ST_PAD);
  assign wrap     = push && (pos_r == sha1_pkg::POS_LAST);
  assign out_xfer = (state_r == sha1_pkg::ST_OUT) && !out_stall;
  assign out_done = out_xfer && (oidx_r == sha1_pkg::OIDX_LAST);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (pos_r == sha1_pkg::POS_LAST) begin
            state_nxt = sha1_pkg::ST_ROUND;
          end else if (in_last_word) begin
            state_nxt = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        if (pos_r == sha1_pkg::POS_LAST) begin
          state_nxt = sha1_pkg::ST_ROUND;
        end
      end
      sha1_pkg::ST_ROUND: begin
        if (rnd_r == sha1_pkg::RND_LAST) begin
          state_nxt = sha1_pkg::ST_ADD;
        end
      end
      sha1_pkg::ST_ADD: begin
        if (hi_r) begin
          state_nxt = sha1_pkg::ST_OUT;
        end else if (pad_r) begin
          state_nxt = sha1_pkg::ST_PAD;
        end else begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_done) begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_stall        = (state_r != sha1_pkg::ST_IDLE);
    out_valid       = (state_r == sha1_pkg::ST_OUT);
    out_digest_last = (oidx_r == sha1_pkg::OIDX_LAST);

    cmd           = '0;
    cmd.accept    = accept;
    cmd.push      = push;
    cmd.load_work = wrap;
    cmd.round_en  = (state_r == sha1_pkg::ST_ROUND);
    cmd.rnd       = rnd_r;
    cmd.add_en    = (state_r == sha1_pkg::ST_ADD);
    cmd.clear     = out_done;
    cmd.out_idx   = oidx_r;

    // Word source: input data in idle, padding words otherwise.
    priority if (state_r == sha1_pkg::ST_IDLE) begin
      cmd.src = in_last_word ? sha1_pkg::SRC_LAST : sha1_pkg::SRC_DATA;
      if (in_last_word && (in_valid_bytes >= sha1_pkg::FULL_BYTES)) begin
        cmd.src = sha1_pkg::SRC_DATA;
      end
    end else if (mark_r) begin
      cmd.src = sha1_pkg::SRC_MARK;
    end else if (pos_r == sha1_pkg::POS_LEN_HI) begin
      cmd.src = sha1_pkg::SRC_LEN_HI;
    end else if ((pos_r == sha1_pkg::POS_LAST) && hi_r) begin
      cmd.src = sha1_pkg::SRC_LEN_LO;
    end else begin
      cmd.src = sha1_pkg::SRC_ZERO;
    end
  end

  // Counters and padding flags.
  always_comb begin
    pos_nxt  = push ? pos_r + 1'b1 : pos_r;
    rnd_nxt  = ((state_r == sha1_pkg::ST_ROUND) && (rnd_r != sha1_pkg::RND_LAST))
               ? rnd_r + 1'b1 : '0;
    oidx_nxt = oidx_r;
    if (out_xfer) begin
      oidx_nxt = out_done ? '0 : oidx_r + 1'b1;
    end
    pad_nxt  = pad_r;
    mark_nxt = mark_r;
    hi_nxt   = hi_r;
    if (accept && in_last_word) begin
      pad_nxt  = 1'b1;
      mark_nxt = (in_valid_bytes >= sha1_pkg::FULL_BYTES);
    end else if (state_r == sha1_pkg::ST_PAD) begin
      if (mark_r) begin
        mark_nxt = 1'b0;
      end else if (pos_r == sha1_pkg::POS_LEN_HI) begin
        hi_nxt = 1'b1;
      end
    end else if (out_done) begin
      pad_nxt = 1'b0;
      hi_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1_pkg::ST_IDLE;
      pos_r   <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      pad_r   <= 1'b0;
      mark_r  <= 1'b0;
      hi_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      pad_r   <= pad_nxt;
      mark_r  <= mark_nxt;
      hi_r    <= hi_nxt;
    end
  end

endmodule

`default_nettype wire
